@@ rtl/core/gcd_pkg.sv @@
package gcd_pkg;

    localparam int CORDIC_STEPS = 32;

    // Angle words in Q30 radians, vector words of the rotation stages.
    localparam int ANG_W = 36;
    localparam int XY_W  = 34;
    localparam int Q_W   = 32;
    localparam int SQ_W  = 62;
    localparam int SQ_STEPS = 31;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]  ONE_XY      = 34'sd1073741824;
    localparam logic [30:0]             ONE_Q30     = 31'd1073741824;
    localparam logic [30:0]             DEG7_TO_RAD = 31'd2012227627;
    localparam logic [23:0]             DIAMETER_M  = 24'd12742000;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            0:  v = 36'sd843314857;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043837;
            3:  v = 36'sd133525159;
            4:  v = 36'sd67021687;
            5:  v = 36'sd33543516;
            6:  v = 36'sd16775851;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194283;
            9:  v = 36'sd2097149;
            10: v = 36'sd1048576;
            default: begin
                if (i <= 30) begin
                    v = ANG_W'(64'sd1 << (30 - i));
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/gcd_sincos.sv @@
module gcd_sincos import gcd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] in_ang,
    output logic                    out_valid,
    output logic signed [Q_W-1:0]   out_sin,
    output logic signed [Q_W-1:0]   out_cos
);

    logic                    wrap_vld_reg;
    logic signed [ANG_W-1:0] wrap_reg;
    logic                    vld_reg [0:CORDIC_STEPS];
    logic                    neg_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  x_reg   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  y_reg   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg   [0:CORDIC_STEPS];
    logic                    fin_vld_reg;
    logic signed [Q_W-1:0]   sin_reg, cos_reg;
    logic signed [XY_W-1:0]  xf, yf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_vld_reg <= 1'b0;
            vld_reg[0]   <= 1'b0;
        end else if (en) begin
            wrap_vld_reg <= in_valid;
            vld_reg[0]   <= wrap_vld_reg;
        end
    end

    // The angle never lies beyond three half turns, so one wrap suffices.
    always_ff @(posedge aclk) begin
        if (en) begin
            priority if (in_ang > PI_Q30) begin
                wrap_reg <= in_ang - TWO_PI_Q30;
            end else if (in_ang < -PI_Q30) begin
                wrap_reg <= in_ang + TWO_PI_Q30;
            end else begin
                wrap_reg <= in_ang;
            end
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            priority if (wrap_reg > HALF_PI_Q30) begin
                z_reg[0]   <= wrap_reg - PI_Q30;
                neg_reg[0] <= 1'b1;
            end else if (wrap_reg < -HALF_PI_Q30) begin
                z_reg[0]   <= wrap_reg + PI_Q30;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0]   <= wrap_reg;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ANG_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
        end
    end

    assign xf = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign yf = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            fin_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            priority if (xf > ONE_XY) begin
                cos_reg <= Q_W'(ONE_XY);
            end else if (xf < -ONE_XY) begin
                cos_reg <= Q_W'(-ONE_XY);
            end else begin
                cos_reg <= Q_W'(xf);
            end
            priority if (yf > ONE_XY) begin
                sin_reg <= Q_W'(ONE_XY);
            end else if (yf < -ONE_XY) begin
                sin_reg <= Q_W'(-ONE_XY);
            end else begin
                sin_reg <= Q_W'(yf);
            end
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;

endmodule

@@ rtl/core/gcd_sqrt.sv @@
module gcd_sqrt import gcd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] in_value,
    output logic        out_valid,
    output logic [30:0] out_root
);

    // Digit-by-digit root of in_value shifted up by 30, one result bit a stage.
    logic            vld_reg  [0:SQ_STEPS];
    logic [SQ_W-1:0] rem_reg  [0:SQ_STEPS];
    logic [SQ_W-1:0] root_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {1'b0, in_value, 30'b0};
            root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
        logic [SQ_W-1:0] trial;
        assign trial = root_reg[j] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[j] >= trial) begin
                    rem_reg[j+1]  <= rem_reg[j] - trial;
                    root_reg[j+1] <= (root_reg[j] >> 1) + BIT;
                end else begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j] >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign out_root  = root_reg[SQ_STEPS][30:0];

endmodule

@@ rtl/core/great_circle_distance_meters.sv @@
// Haversine great-circle distance between two points on a sphere of radius 6371 km.
// The slave channel takes one item per pair of points: two latitudes and two
// longitudes in signed units of 1e-7 degree. The master channel returns one
// item per input item, the distance in whole meters truncated toward zero.
// The block is a single pipeline: an item may enter in every clock cycle while
// the receiver does not stall, so the throughput is one item per cycle. The
// pipeline holds two chains of rotation stages (sine and cosine, then
// arctangent) and the 31 stages of the square root.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready falls in the same cycle; no item is lost or repeated, and input
// is taken again as soon as the waiting result is taken.
// A synchronous reset clears every valid bit; the payload registers keep
// whatever they held and are ignored until new items arrive.
module great_circle_distance_meters import gcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude[30:0], first_longitude[62:31], second_latitude[93:63],
    // second_longitude[125:94], zero fill above.
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_meters[24:0], zero fill above.
    output logic [31:0]  m_tdata
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Angle slots: half latitude difference, half longitude difference,
    // first latitude, second latitude.
    logic signed [33:0] u_reg [0:3];
    logic [32:0]        mag_reg [0:3];
    logic               neg2_reg [0:3];
    logic [46:0]        plo_reg [0:3];
    logic [47:0]        phi_reg [0:3];
    logic               neg3_reg [0:3];
    logic [33:0]        rmag_reg [0:3];
    logic               neg4_reg [0:3];
    logic signed [ANG_W-1:0] ang_reg [0:3];
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;

    logic signed [33:0] lat1, lon1, lat2, lon2;
    assign lat1 = {{3{s_tdata[30]}}, s_tdata[30:0]};
    assign lon1 = {{2{s_tdata[62]}}, s_tdata[62:31]};
    assign lat2 = {{3{s_tdata[93]}}, s_tdata[93:63]};
    assign lon2 = {{2{s_tdata[125]}}, s_tdata[125:94]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    logic [63:0] conv_sum [0:3];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            conv_sum[k] = {phi_reg[k], 16'b0} + {17'b0, plo_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0] <= lat2 - lat1;
            u_reg[1] <= lon2 - lon1;
            u_reg[2] <= lat1;
            u_reg[3] <= lat2;
            for (int k = 0; k < 4; k++) begin
                mag_reg[k]  <= u_reg[k][33] ? 33'(-u_reg[k]) : u_reg[k][32:0];
                neg2_reg[k] <= u_reg[k][33];
                plo_reg[k]  <= mag_reg[k][15:0] * DEG7_TO_RAD;
                phi_reg[k]  <= mag_reg[k][32:16] * DEG7_TO_RAD;
                neg3_reg[k] <= neg2_reg[k];
                // The two differences are needed as half angles.
                rmag_reg[k] <= (k < 2) ? 34'(conv_sum[k] >> 31) : 34'(conv_sum[k] >> 30);
                neg4_reg[k] <= neg3_reg[k];
                ang_reg[k]  <= neg4_reg[k] ? -ANG_W'($signed({1'b0, rmag_reg[k]}))
                                           :  ANG_W'($signed({1'b0, rmag_reg[k]}));
            end
        end
    end

    logic                  sc_vld;
    logic signed [Q_W-1:0] sin_v [0:3];
    logic signed [Q_W-1:0] cos_v [0:3];

    gcd_sincos u_sc0 (.aclk, .aresetn, .en, .in_valid(vld5_reg), .in_ang(ang_reg[0]),
                      .out_valid(sc_vld), .out_sin(sin_v[0]), .out_cos(cos_v[0]));
    gcd_sincos u_sc1 (.aclk, .aresetn, .en, .in_valid(vld5_reg), .in_ang(ang_reg[1]),
                      .out_valid(), .out_sin(sin_v[1]), .out_cos(cos_v[1]));
    gcd_sincos u_sc2 (.aclk, .aresetn, .en, .in_valid(vld5_reg), .in_ang(ang_reg[2]),
                      .out_valid(), .out_sin(sin_v[2]), .out_cos(cos_v[2]));
    gcd_sincos u_sc3 (.aclk, .aresetn, .en, .in_valid(vld5_reg), .in_ang(ang_reg[3]),
                      .out_valid(), .out_sin(sin_v[3]), .out_cos(cos_v[3]));

    logic signed [63:0] pcc_reg, plon_reg, plat_reg, pterm_reg;
    logic signed [31:0] dl2_reg;
    logic [30:0]        a_reg;
    logic               vp1_reg, vp2_reg, vp3_reg;
    logic signed [31:0] cc, sl2;
    logic signed [33:0] asum;

    assign cc   = 32'(pcc_reg >>> 30);
    assign sl2  = 32'(plon_reg >>> 30);
    assign asum = 34'(pterm_reg >>> 30) + 34'(dl2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
        end else if (en) begin
            vp1_reg <= sc_vld;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pcc_reg   <= cos_v[2] * cos_v[3];
            plon_reg  <= sin_v[1] * sin_v[1];
            plat_reg  <= sin_v[0] * sin_v[0];
            pterm_reg <= cc * sl2;
            dl2_reg   <= 32'(plat_reg >>> 30);
            priority if (asum[33]) begin
                a_reg <= '0;
            end else if (asum > 34'($signed({1'b0, ONE_Q30}))) begin
                a_reg <= ONE_Q30;
            end else begin
                a_reg <= asum[30:0];
            end
        end
    end

    logic        sq_vld;
    logic [30:0] root_a, root_b, one_minus_a;
    assign one_minus_a = ONE_Q30 - a_reg;

    gcd_sqrt u_sqa (.aclk, .aresetn, .en, .in_valid(vp3_reg), .in_value(a_reg),
                    .out_valid(sq_vld), .out_root(root_a));
    gcd_sqrt u_sqb (.aclk, .aresetn, .en, .in_valid(vp3_reg), .in_value(one_minus_a),
                    .out_valid(), .out_root(root_b));

    // Vectoring rotation towards y = 0 gives the central half-angle.
    logic                    avld_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  ax_reg   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  ay_reg   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] az_reg   [0:CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avld_reg[0] <= 1'b0;
        end else if (en) begin
            avld_reg[0] <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= XY_W'({1'b0, root_b});
            ay_reg[0] <= XY_W'({1'b0, root_a});
            az_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                avld_reg[i+1] <= 1'b0;
            end else if (en) begin
                avld_reg[i+1] <= avld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!ay_reg[i][XY_W-1]) begin
                    ax_reg[i+1] <= ax_reg[i] + (ay_reg[i] >>> i);
                    ay_reg[i+1] <= ay_reg[i] - (ax_reg[i] >>> i);
                    az_reg[i+1] <= az_reg[i] + atan_entry(i);
                end else begin
                    ax_reg[i+1] <= ax_reg[i] - (ay_reg[i] >>> i);
                    ay_reg[i+1] <= ay_reg[i] + (ax_reg[i] >>> i);
                    az_reg[i+1] <= az_reg[i] - atan_entry(i);
                end
            end
        end
    end

    logic        hv_reg, dv_reg, m_tvalid_reg;
    logic [30:0] half_ang_reg;
    logic [54:0] dprod_reg;
    logic [31:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg       <= 1'b0;
            dv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            hv_reg       <= avld_reg[CORDIC_STEPS];
            dv_reg       <= hv_reg;
            m_tvalid_reg <= dv_reg;
        end
    end

    // The product shifted down by 30 already fits the 25-bit result.
    always_ff @(posedge aclk) begin
        if (en) begin
            half_ang_reg <= az_reg[CORDIC_STEPS][ANG_W-1] ? 31'd0
                                                          : az_reg[CORDIC_STEPS][30:0];
            dprod_reg    <= DIAMETER_M * half_ang_reg;
            m_tdata_reg  <= {7'b0, dprod_reg[54:30]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld1_reg)
        else $error("accepted item missing from the first stage");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(avld_reg[CORDIC_STEPS]) && $stable(az_reg[CORDIC_STEPS]))
        else $error("arctangent stage moved during a stall");
    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vp3_reg |-> a_reg <= ONE_Q30 && one_minus_a <= ONE_Q30)
        else $error("haversine term out of range");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import gcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * CORDIC_STEPS + 80;
    localparam longint DEG_FACTOR = 64'd2012227627;
    localparam longint ONE_Q      = 64'sd1073741824;
    localparam longint PI_Q       = 64'sd3373259426;
    localparam longint HALF_PI_Q  = 64'sd1686629713;
    localparam longint TWO_PI_Q   = 64'sd6746518852;
    localparam longint GAIN_Q     = 64'sd652032874;
    localparam longint DIAM       = 64'sd12742000;
    localparam longint DIST_MAX   = 64'sd33554431;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    logic [24:0] distance_queue[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          quiet_cycles;
    int          items_sent;
    int          results_seen;

    great_circle_distance_meters u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint angle_entry(int i);
        longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11) return tbl[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint clamp_q(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // 1e-7 degree units to Q30 radians; half selects the half angle.
    function automatic longint units_to_rad(longint units, int half);
        longint unsigned mag;
        longint r;
        mag = units < 0 ? longint'(-units) : longint'(units);
        r = longint'((mag * DEG_FACTOR) >> (30 + half));
        return units < 0 ? -r : r;
    endfunction

    function automatic void rotate_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint x, y, z, nx;
        bit     flip;
        x = GAIN_Q;
        y = 0;
        z = ang;
        flip = 1'b0;
        while (z > PI_Q) z -= TWO_PI_Q;
        while (z < -PI_Q) z += TWO_PI_Q;
        if (z > HALF_PI_Q) begin
            z -= PI_Q;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q) begin
            z += PI_Q;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= angle_entry(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += angle_entry(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_q(x, -ONE_Q, ONE_Q);
        s = clamp_q(y, -ONE_Q, ONE_Q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += angle_entry(i);
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= angle_entry(i);
            end
            x = nx;
        end
        return z < 0 ? 0 : z;
    endfunction

    function automatic logic [24:0] haversine_meters(logic signed [30:0] lat1,
                                                     logic signed [31:0] lon1,
                                                     logic signed [30:0] lat2,
                                                     logic signed [31:0] lon2);
        longint sdl, cdl, sdo, cdo, s1, c1, s2, c2, cc, term, a, ra, rb, ang, d;
        rotate_sin_cos(units_to_rad(longint'(lat2) - longint'(lat1), 1), sdl, cdl);
        rotate_sin_cos(units_to_rad(longint'(lon2) - longint'(lon1), 1), sdo, cdo);
        rotate_sin_cos(units_to_rad(longint'(lat1), 0), s1, c1);
        rotate_sin_cos(units_to_rad(longint'(lat2), 0), s2, c2);
        cc = (c1 * c2) >>> 30;
        term = (cc * ((sdo * sdo) >>> 30)) >>> 30;
        a = clamp_q(((sdl * sdl) >>> 30) + term, 0, ONE_Q);
        ra = longint'(int_sqrt(longint'(a) << 30));
        rb = longint'(int_sqrt(longint'(ONE_Q - a) << 30));
        ang = vector_angle(ra, rb);
        d = (DIAM * ang) >>> 30;
        return 25'(clamp_q(d, 0, DIST_MAX));
    endfunction

    task automatic send_points(logic signed [30:0] lat1, logic signed [31:0] lon1,
                               logic signed [30:0] lat2, logic signed [31:0] lon2);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, lon2, lat2, lon1, lat1};
        do @(posedge aclk); while (!s_tready);
        distance_queue.push_back(haversine_meters(lat1, lon1, lat2, lon2));
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (distance_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
    endfunction

    task automatic test_directed();
        send_points(31'sd0, 32'sd0, 31'sd0, 32'sd0);
        send_points(31'sd900000000, 32'sd1800000000, 31'sd900000000, 32'sd1800000000);
        send_points(31'sd0, 32'sd0, 31'sd0, 32'sd1800000000);
        send_points(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000);
        send_points(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
        send_points(-31'sd900000000, -32'sd1800000000, 31'sd900000000, 32'sd1800000000);
        send_points(31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000);
        send_points(31'sd1, 32'sd0, 31'sd0, 32'sd1);
        send_points(31'sd0, 32'sd0, 31'sd1, 32'sd0);
        send_points(31'sd515000000, -32'sd1270000, 31'sd407000000, -32'sd740000000);
        // Coordinates outside the legal ranges, raw bit extremes.
        send_points(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000);
        send_points(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff);
        send_points(31'h7fffffff, 32'hffffffff, 31'h00000000, 32'h00000000);
        send_points(31'h3fffffff, 32'h80000000, 31'h3fffffff, 32'h80000000);
        send_points(31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000);
        send_points(31'sd10, -32'sd1799999990, -31'sd10, 32'sd10);
        wait_for_results();
    endtask

    task automatic test_random(int count);
        logic signed [30:0] la1, la2;
        logic signed [31:0] lo1, lo2;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            la1 = rand_lat();
            lo1 = rand_lon();
            if (pick < 20) begin
                la2 = 31'($urandom);
                lo2 = $urandom;
                la1 = 31'($urandom);
                lo1 = $urandom;
            end else if (pick < 35) begin
                // Nearby points, a short distance.
                la2 = la1 + 31'(int'($urandom_range(0, 20000)) - 10000);
                lo2 = lo1 + 32'(int'($urandom_range(0, 20000)) - 10000);
            end else if (pick < 45) begin
                // Almost antipodal.
                la2 = -la1 + 31'(int'($urandom_range(0, 2000)) - 1000);
                lo2 = lo1 + (lo1 < 0 ? 32'sd1800000000 : -32'sd1800000000);
            end else begin
                la2 = rand_lat();
                lo2 = rand_lon();
            end
            send_points(la1, lo1, la2, lo2);
        end
    endtask

    task automatic test_drain_pause();
        test_random(40);
        wait_for_results();
        test_random(40);
    endtask

    // Result checker and receiver pacing.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (distance_queue.size() == 0) begin
                    $error("distance_meters: result %0d with nothing expected", m_tdata);
                    error_count++;
                end else begin
                    if (m_tdata[24:0] != distance_queue[0] || m_tdata[31:25] != 0) begin
                        $error("distance_meters: expected %0d, actual %0d",
                               distance_queue[0], m_tdata);
                        error_count++;
                    end
                    void'(distance_queue.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding",
                         distance_queue.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 68;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(600);
        test_drain_pause();
        send_idle_pct = 68;
        recv_idle_pct = 22;
        test_random(560);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d point pairs (extremes, equal, antipodal, out of range, random)",
                 items_sent);
        $display("Checked %0d distances under three sender and receiver stall mixes",
                 results_seen);
        if (error_count == 0 && distance_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ great_circle_distance_meters.f @@
rtl/core/gcd_pkg.sv
rtl/core/gcd_sincos.sv
rtl/core/gcd_sqrt.sv
rtl/core/great_circle_distance_meters.sv
tb/sv/tb_top.sv
